/* src/sks_pkg.sv */
// Shared types and constants for the sorted key set block.
// No dependencies; used by sks_front, sks_back and sorted_key_set.
`default_nettype none
package sks_pkg;

   localparam int unsigned DEF_CAPACITY  = 64;
   localparam int unsigned DEF_KEY_WIDTH = 32;
   localparam int unsigned IN_KEY_W      = 32;
   localparam int unsigned OUT_CNT_W     = 7;

   typedef enum logic {
      REQ_LOOKUP = 1'b0,
      REQ_ADD    = 1'b1
   } req_code_type;

   // one queued item, already classified
   typedef struct packed {
      logic                is_add;
      logic [IN_KEY_W-1:0] key;
   } item_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PROBE  = 7'b0000010,
      ST_CMP    = 7'b0000100,
      ST_DECIDE = 7'b0001000,
      ST_SHRD   = 7'b0010000,
      ST_SHWR   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

endpackage
`default_nettype wire

/* src/sorted_key_set.sv */
// Sorted key set: holds up to CAPACITY keys in ascending order in one key
// memory. A lookup reports presence and index or insertion point; an add
// inserts an absent key when there is room. A request goes through a pop
// state, a read and a compare state per binary-search probe (at most
// ceil(log2(count+1)) probes), a closing check when no key matches, a
// decide state and a result state that waits until the last result is
// taken; an insert then moves each larger key up a slot by a read and a
// write, then writes the new key. Depends on sks_pkg. A two-entry request
// queue takes new items while the engine works. Write signedness
// (csr_signed_keys) only while idle; the block does not enforce it.
`default_nettype none
module sorted_key_set #(
   parameter int unsigned CAPACITY  = sks_pkg::DEF_CAPACITY,
   parameter int unsigned KEY_WIDTH = sks_pkg::DEF_KEY_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_signed_keys,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_type,
   input  wire logic [sks_pkg::IN_KEY_W-1:0]  req_key,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic [sks_pkg::OUT_CNT_W-1:0]      rsp_position,
   output logic                               rsp_inserted,
   output logic                               rsp_table_full,
   output logic [sks_pkg::OUT_CNT_W-1:0]      rsp_entry_count
);
   import sks_pkg::*;

   logic     signed_ff, signed_in;
   logic     q_valid, q_pop;
   item_type q_item;

   assign csr_ready = 1'b1;
   assign signed_in = (csr_valid && csr_ready) ? csr_signed_keys : signed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_ff <= 1'b0;
      end else begin
         signed_ff <= signed_in;
      end
   end

   sks_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_key   (req_key),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   sks_back #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .signed_keys     (signed_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_inserted    (rsp_inserted),
      .rsp_table_full  (rsp_table_full),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
`default_nettype wire

/* src/sks_front.sv */
// Front end: accepts requests, classifies them and holds them in a
// two-entry queue for the search engine. Depends on sks_pkg.
`default_nettype none
module sks_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_type,
   input  wire logic [sks_pkg::IN_KEY_W-1:0]  req_key,
   output logic                               q_valid,
   output sks_pkg::item_type                  q_item,
   input  wire logic                          q_pop
);
   import sks_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].is_add <= (req_type == REQ_ADD);
         slot_ff[wr_ptr_ff].key    <= req_key;
      end
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2) else $error("queue lost an item");
   a_ptr_cnt: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff)) else $error("queue pointers off");
`endif

endmodule
`default_nettype wire

/* src/sks_back.sv */
// Back end: binary search over the key memory, shifting insert, and the
// result register. Depends on sks_pkg.
`default_nettype none
module sks_back #(
   parameter int unsigned CAPACITY  = sks_pkg::DEF_CAPACITY,
   parameter int unsigned KEY_WIDTH = sks_pkg::DEF_KEY_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           signed_keys,
   input  wire logic                           q_valid,
   input  wire sks_pkg::item_type              q_item,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_found,
   output logic [sks_pkg::OUT_CNT_W-1:0]       rsp_position,
   output logic                                rsp_inserted,
   output logic                                rsp_table_full,
   output logic [sks_pkg::OUT_CNT_W-1:0]       rsp_entry_count
);
   import sks_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   logic [KEY_WIDTH-1:0] key_mem [CAPACITY];
   logic [KEY_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;
   logic                 rd_en, wr_en;

   state_type            state_ff, state_in;
   logic                 is_add_ff, is_add_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]        lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CW-1:0]        idx_ff, idx_in, count_ff, count_in;
   logic                 hit_ff, hit_in, ins_ff, ins_in, full_ff, full_in;
   logic [CW:0]          mid_sum;
   logic [CW-1:0]        mid, idx_dec;
   logic [KEY_WIDTH-1:0] want, have, sign_mask;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       found_ff, inserted_ff, full_out_ff;
   logic [OUT_CNT_W-1:0]       position_ff, count_out_ff;
   logic                       load_out;

   assign sign_mask = KEY_WIDTH'(signed_keys) << (KEY_WIDTH - 1);
   assign want      = key_ff ^ sign_mask;
   assign have      = rd_data_ff ^ sign_mask;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CW:1];
   assign idx_dec   = idx_ff - 1'b1;

   always_comb begin
      state_in  = state_ff;
      is_add_in = is_add_ff;
      key_in    = key_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      hit_in    = hit_ff;
      ins_in    = ins_ff;
      full_in   = full_ff;
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = mid[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = rd_data_ff;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               is_add_in = q_item.is_add;
               key_in    = KEY_WIDTH'(q_item.key);
               lo_in     = '0;
               hi_in     = count_ff;
               hit_in    = 1'b0;
               ins_in    = 1'b0;
               full_in   = 1'b0;
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               mid_in   = mid;
               state_in = ST_CMP;
            end else begin
               mid_in   = lo_ff;
               state_in = ST_DECIDE;
            end
         end
         ST_CMP: begin
            if (want < have) begin
               hi_in    = mid_ff;
               state_in = ST_PROBE;
            end else if (want > have) begin
               lo_in    = mid_ff + 1'b1;
               state_in = ST_PROBE;
            end else begin
               hit_in   = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // mid_ff now holds the match index or the insertion point
            if (is_add_ff && !hit_ff) begin
               if (count_ff == CAP) begin
                  full_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  idx_in   = count_ff;
                  state_in = ST_SHRD;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SHRD: begin
            if (idx_ff > mid_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_dec[AW-1:0];
               state_in = ST_SHWR;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = mid_ff[AW-1:0];
               wr_data  = key_ff;
               count_in = count_ff + 1'b1;
               ins_in   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_SHWR: begin
            // move one larger key up a slot
            wr_en    = 1'b1;
            idx_in   = idx_dec;
            state_in = ST_SHRD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_add_ff <= is_add_in;
      key_ff    <= key_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      ins_ff    <= ins_in;
      full_ff   <= full_in;
      if (load_out) begin
         found_ff     <= hit_ff;
         position_ff  <= OUT_CNT_W'(mid_ff);
         inserted_ff  <= ins_ff;
         full_out_ff  <= full_ff;
         count_out_ff <= OUT_CNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_position    = position_ff;
   assign rsp_inserted    = inserted_ff;
   assign rsp_table_full  = full_out_ff;
   assign rsp_entry_count = count_out_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP) else $error("entry count above capacity");
   a_ins_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inserted) |-> (!rsp_found && !rsp_table_full))
      else $error("inserted with found or full");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + 1'b1))
      else $error("entry count moved by other than one");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_PROBE) else $error("pop outside idle");
`endif

endmodule
`default_nettype wire
